>>> hw/rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg: modular exponentiation shared definitions
// Control word layout, step addresses, microcode program and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  localparam int PC_W   = 4;
  localparam int ACT_W  = 4;
  localparam int COND_W = 4;

  // step addresses of the program
  localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] S_CHK0  = 4'd1;
  localparam logic [PC_W-1:0] S_CHK1  = 4'd2;
  localparam logic [PC_W-1:0] S_RCHK  = 4'd3;
  localparam logic [PC_W-1:0] S_RED   = 4'd4;
  localparam logic [PC_W-1:0] S_RWAIT = 4'd5;
  localparam logic [PC_W-1:0] S_CHKE1 = 4'd6;
  localparam logic [PC_W-1:0] S_LOOP  = 4'd7;
  localparam logic [PC_W-1:0] S_ODD   = 4'd8;
  localparam logic [PC_W-1:0] S_MULA  = 4'd9;
  localparam logic [PC_W-1:0] S_WAITA = 4'd10;
  localparam logic [PC_W-1:0] S_SQ    = 4'd11;
  localparam logic [PC_W-1:0] S_WAITS = 4'd12;
  localparam logic [PC_W-1:0] S_JMP   = 4'd13;
  localparam logic [PC_W-1:0] S_FIN   = 4'd14;
  localparam logic [PC_W-1:0] S_EMIT  = 4'd15;

  // datapath actions
  localparam logic [ACT_W-1:0] A_NONE     = 4'd0;
  localparam logic [ACT_W-1:0] A_LOAD     = 4'd1;
  localparam logic [ACT_W-1:0] A_RES_ZERO = 4'd2;
  localparam logic [ACT_W-1:0] A_RES_ONE  = 4'd3;
  localparam logic [ACT_W-1:0] A_RES_BASE = 4'd4;
  localparam logic [ACT_W-1:0] A_RES_ACC  = 4'd5;
  localparam logic [ACT_W-1:0] A_MUL_RED  = 4'd6;
  localparam logic [ACT_W-1:0] A_MUL_ACC  = 4'd7;
  localparam logic [ACT_W-1:0] A_MUL_SQ   = 4'd8;
  localparam logic [ACT_W-1:0] A_EMIT     = 4'd9;

  // jump conditions
  localparam logic [COND_W-1:0] C_NEVER       = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS      = 4'd1;
  localparam logic [COND_W-1:0] C_NO_INPUT    = 4'd2;
  localparam logic [COND_W-1:0] C_BASE_ZERO   = 4'd3;
  localparam logic [COND_W-1:0] C_EXP_ZERO    = 4'd4;
  localparam logic [COND_W-1:0] C_BASE_LE_MOD = 4'd5;
  localparam logic [COND_W-1:0] C_EXP_ONE     = 4'd6;
  localparam logic [COND_W-1:0] C_EXP_EVEN    = 4'd7;
  localparam logic [COND_W-1:0] C_MUL_BUSY    = 4'd8;
  localparam logic [COND_W-1:0] C_OUT_BUSY    = 4'd9;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } mexp_cw_t;

  // status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic base_zero;
    logic exp_zero;
    logic base_le_mod;
    logic exp_one;
    logic exp_even;
    logic mul_busy;
    logic out_busy;
  } mexp_flags_t;

  // modular multiplier status
  typedef struct packed {
    logic busy;
    logic done;
  } mexp_mm_stat_t;

  // microcode program, one control word per step
  function automatic mexp_cw_t mexp_rom(input logic [PC_W-1:0] pc);
    mexp_cw_t cw;
    case (pc)
      S_IDLE:  cw = '{A_LOAD,     C_NO_INPUT,    S_IDLE};
      S_CHK0:  cw = '{A_RES_ZERO, C_BASE_ZERO,   S_EMIT};
      S_CHK1:  cw = '{A_RES_ONE,  C_EXP_ZERO,    S_EMIT};
      S_RCHK:  cw = '{A_NONE,     C_BASE_LE_MOD, S_CHKE1};
      S_RED:   cw = '{A_MUL_RED,  C_NEVER,       S_IDLE};
      S_RWAIT: cw = '{A_NONE,     C_MUL_BUSY,    S_RWAIT};
      S_CHKE1: cw = '{A_RES_BASE, C_EXP_ONE,     S_EMIT};
      S_LOOP:  cw = '{A_NONE,     C_EXP_ZERO,    S_FIN};
      S_ODD:   cw = '{A_NONE,     C_EXP_EVEN,    S_SQ};
      S_MULA:  cw = '{A_MUL_ACC,  C_NEVER,       S_IDLE};
      S_WAITA: cw = '{A_NONE,     C_MUL_BUSY,    S_WAITA};
      S_SQ:    cw = '{A_MUL_SQ,   C_NEVER,       S_IDLE};
      S_WAITS: cw = '{A_NONE,     C_MUL_BUSY,    S_WAITS};
      S_JMP:   cw = '{A_NONE,     C_ALWAYS,      S_LOOP};
      S_FIN:   cw = '{A_RES_ACC,  C_NEVER,       S_IDLE};
      S_EMIT:  cw = '{A_EMIT,     C_OUT_BUSY,    S_EMIT};
      default: cw = '{A_NONE,     C_ALWAYS,      S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod: iterative modular multiplier
// Interleaved shift-add: one multiplier bit per cycle, MSB first, with the
// running remainder kept below the modulus by conditional subtracts.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_mulmod #(
  parameter int W = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [W-1:0]           x,
  input  wire logic [W-1:0]           y,
  input  wire logic [W:0]             m_eff,
  output logic      [W-1:0]           result,
  output mexp_pkg::mexp_mm_stat_t     stat
);

  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     x_r, x_nxt;
  logic [W-1:0]     y_r, y_nxt;
  logic [W-1:0]     r_r, r_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [W:0] y_ext;
  logic [W:0] y_red;
  logic [W:0] dbl;
  logic [W:0] dbl_red;
  logic [W:0] sum;
  logic [W:0] sum_red;

  // operand may equal the modulus, bring it below once
  always_comb begin
    y_ext = {1'b0, y};
    y_red = (y_ext >= m_eff) ? (y_ext - m_eff) : y_ext;
  end

  // one step: r = (2r + bit*y) mod m
  always_comb begin
    dbl     = {r_r, 1'b0};
    dbl_red = (dbl >= m_eff) ? (dbl - m_eff) : dbl;
    sum     = dbl_red + (x_r[W-1] ? {1'b0, y_r} : {(W+1){1'b0}});
    sum_red = (sum >= m_eff) ? (sum - m_eff) : sum;
  end

  // next state
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = x;
      y_nxt    = y_red[W-1:0];
      r_nxt    = '0;
      cnt_nxt  = CNT_W'(W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt   = {x_r[W-2:0], 1'b0};
      r_nxt   = sum_red[W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    r_r   <= r_nxt;
    cnt_r <= cnt_nxt;
  end

  assign result    = r_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

>>> hw/rtl/mexp_useq.sv
// ----------------------------------------------------------------------------
// mexp_useq: microcode sequencer
// Step counter over the program table with conditional jumps on status flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_useq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mexp_pkg::mexp_flags_t flags,
  output mexp_pkg::mexp_cw_t         cw
);

  logic [mexp_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                      take;

  assign cw = mexp_pkg::mexp_rom(pc_r);

  // jump condition select
  always_comb begin
    case (cw.cond)
      mexp_pkg::C_NEVER:       take = 1'b0;
      mexp_pkg::C_ALWAYS:      take = 1'b1;
      mexp_pkg::C_NO_INPUT:    take = !flags.in_valid;
      mexp_pkg::C_BASE_ZERO:   take = flags.base_zero;
      mexp_pkg::C_EXP_ZERO:    take = flags.exp_zero;
      mexp_pkg::C_BASE_LE_MOD: take = flags.base_le_mod;
      mexp_pkg::C_EXP_ONE:     take = flags.exp_one;
      mexp_pkg::C_EXP_EVEN:    take = flags.exp_even;
      mexp_pkg::C_MUL_BUSY:    take = flags.mul_busy;
      mexp_pkg::C_OUT_BUSY:    take = flags.out_busy;
      default:                 take = 1'b0;
    endcase
  end

  // fall through wraps from the last step back to idle
  assign pc_nxt = take ? cw.target : pc_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= mexp_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation: right-to-left binary modular power
// Microcoded datapath: base, exponent, accumulator and result registers
// driven by a program table, with one shared iterative modular multiplier.
//
//   channel | dir | handshake              | payload
//   in      | in  | in_tvalid / in_tready  | in_tdata: base_value, exponent
//   out     | out | out_tvalid / out_tready| out_tdata: power_residue
//   cfg     | in  | cfg_wen                | cfg_wdata: modulus
//
// Each modular multiply runs in the shared multiplier, one bit of the
// multiplier operand per cycle.
// An item takes one squaring for each clear and a multiply plus a squaring
// for each set exponent bit up to the top set bit, plus one reduction
// multiply when the base is above the modulus; zero base, zero exponent
// and exponent one skip the square-and-multiply loop.
// Synchronous active-low reset returns the sequencer to idle and sets the
// modulus to 65521. One item is in work at a time; a finished result waits in
// the output register while the next item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input requests
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] base_value, [63:32] exponent
  // result requests
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] power_residue
  // modulus register
  input  wire logic        cfg_wen,
  input  wire logic [31:0] cfg_wdata
);

  localparam int W = OPERAND_WIDTH;

  mexp_pkg::mexp_cw_t      cw;
  mexp_pkg::mexp_flags_t   flags;
  mexp_pkg::mexp_mm_stat_t mm_stat;

  logic [31:0]  mod_r;
  logic [W-1:0] base_r, base_nxt;
  logic [W-1:0] exp_r, exp_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] res_r, res_nxt;
  logic         dest_acc_r, dest_acc_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_data_r, out_data_nxt;

  logic [W-1:0] m;
  logic [W:0]   m_eff;
  logic         in_fire;
  logic         out_busy;
  logic         mm_start;
  logic [W-1:0] mm_x, mm_y, mm_result;

  // a zero modulus means arithmetic modulo 2^W
  assign m     = mod_r[W-1:0];
  assign m_eff = {(m == '0), m};

  assign in_tready = (cw.act == mexp_pkg::A_LOAD);
  assign in_fire   = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;

  // status flags for the sequencer
  always_comb begin
    flags.in_valid    = in_tvalid;
    flags.base_zero   = (base_r == '0);
    flags.exp_zero    = (exp_r == '0);
    flags.base_le_mod = ({1'b0, base_r} <= m_eff);
    flags.exp_one     = (exp_r == W'(1));
    flags.exp_even    = !exp_r[0];
    flags.mul_busy    = mm_stat.busy;
    flags.out_busy    = out_busy;
  end

  mexp_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .cw    (cw)
  );

  // multiplier operand select
  always_comb begin
    mm_start = 1'b0;
    mm_x     = base_r;
    mm_y     = base_r;
    case (cw.act)
      mexp_pkg::A_MUL_RED: begin
        mm_start = 1'b1;
        mm_y     = W'(1);
      end
      mexp_pkg::A_MUL_ACC: begin
        mm_start = 1'b1;
        mm_x     = acc_r;
      end
      mexp_pkg::A_MUL_SQ: begin
        mm_start = 1'b1;
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  mexp_mulmod #(
    .W (W)
  ) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start),
    .x      (mm_x),
    .y      (mm_y),
    .m_eff  (m_eff),
    .result (mm_result),
    .stat   (mm_stat)
  );

  // datapath register updates
  always_comb begin
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    dest_acc_nxt  = dest_acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (mm_stat.done) begin
      if (dest_acc_r) begin
        acc_nxt = mm_result;
      end else begin
        base_nxt = mm_result;
      end
    end
    case (cw.act)
      mexp_pkg::A_LOAD: begin
        if (in_fire) begin
          base_nxt = in_tdata[W-1:0];
          exp_nxt  = in_tdata[32+W-1:32];
          acc_nxt  = W'(1);
        end
      end
      mexp_pkg::A_RES_ZERO: res_nxt = '0;
      mexp_pkg::A_RES_ONE:  res_nxt = W'(1);
      mexp_pkg::A_RES_BASE: res_nxt = base_r;
      mexp_pkg::A_RES_ACC:  res_nxt = acc_r;
      mexp_pkg::A_MUL_RED:  dest_acc_nxt = 1'b0;
      mexp_pkg::A_MUL_ACC:  dest_acc_nxt = 1'b1;
      mexp_pkg::A_MUL_SQ: begin
        dest_acc_nxt = 1'b0;
        exp_nxt      = exp_r >> 1;
      end
      mexp_pkg::A_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= 32'd65521;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        mod_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    exp_r      <= exp_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    dest_acc_r <= dest_acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 32'(out_data_r);

endmodule

`default_nettype wire

>>> hw/rtl/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker: port-level checks for modular_exponentiation
// Watches the stream handshakes and the request sequencing of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // one request in work at a time: no back-to-back accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous request in work");

  // a new result never appears while the block is idle for input
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a request in work");

  // reset empties the output register
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

>>> test/tb_modular_exponentiation.sv
// ----------------------------------------------------------------------------
// tb_modular_exponentiation: self-checking bench for the modular power block
// Directed rows followed by random requests over several modulus settings.
// Every accepted request without a known residue is predicted in the bench
// with a right-to-left square and multiply, and every result is checked in
// order. Both sides idle at random, and the result side holds off once for a
// long stretch.
`default_nettype none

module tb_modular_exponentiation;

  localparam logic [31:0] MODULUS_AT_RESET = 32'd65521;
  localparam int          ROWS             = 22;
  localparam int          PHASES           = 7;
  localparam int          PER_PHASE        = 37;
  localparam int          HOLD_CYCLES      = 6000;
  localparam int          HOLD_AFTER       = 40;
  localparam int          WATCHDOG_LIMIT   = 30000;
  localparam int          TAIL_CYCLES      = 50;

  typedef struct packed {
    logic [31:0] modulus;
    logic [31:0] base_value;
    logic [31:0] exponent;
    logic        known;
    logic [31:0] residue;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [31:0] base_value, [63:32] exponent
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] power_residue
  logic        cfg_wen = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // modulus as the block should hold it, and what is on offer right now
  logic [31:0] modulus_now = MODULUS_AT_RESET;
  logic        offer_known = 1'b0;
  logic [31:0] offer_residue = '0;

  logic [31:0] residue_q[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          stalled_cycles = 0;
  logic        send_burst = 1'b0;
  logic        recv_burst = 1'b0;

  // directed rows: extremes, every special case except a zero modulus, expected value where obvious
  vector_t directed_rows [ROWS] = '{
    '{MODULUS_AT_RESET, 32'd0,          32'd0,          1'b1, 32'd0},
    '{MODULUS_AT_RESET, 32'd0,          32'hFFFFFFFF,   1'b1, 32'd0},
    '{MODULUS_AT_RESET, 32'd5,          32'd0,          1'b1, 32'd1},
    '{MODULUS_AT_RESET, 32'hFFFFFFFF,   32'd0,          1'b1, 32'd1},
    '{MODULUS_AT_RESET, 32'd65521,      32'd1,          1'b1, 32'd65521},
    '{MODULUS_AT_RESET, 32'd65522,      32'd1,          1'b1, 32'd1},
    '{MODULUS_AT_RESET, 32'hFFFFFFFF,   32'd1,          1'b0, 32'd0},
    '{MODULUS_AT_RESET, 32'd2,          32'd16,         1'b0, 32'd0},
    '{MODULUS_AT_RESET, 32'd3,          32'hFFFFFFFF,   1'b0, 32'd0},
    '{MODULUS_AT_RESET, 32'hFFFFFFFF,   32'hFFFFFFFF,   1'b0, 32'd0},
    '{MODULUS_AT_RESET, 32'd1,          32'hFFFFFFFF,   1'b1, 32'd1},
    '{MODULUS_AT_RESET, 32'd65521,      32'd2,          1'b0, 32'd0},
    '{32'd1,            32'd0,          32'd0,          1'b1, 32'd0},
    '{32'd1,            32'd7,          32'd0,          1'b1, 32'd1},
    '{32'd1,            32'd1,          32'd1,          1'b1, 32'd1},
    '{32'd1,            32'd2,          32'd1,          1'b1, 32'd0},
    '{32'd1,            32'hFFFFFFFF,   32'hFFFFFFFF,   1'b0, 32'd0},
    '{32'hFFFFFFFF,     32'hFFFFFFFF,   32'd1,          1'b1, 32'hFFFFFFFF},
    '{32'hFFFFFFFF,     32'hFFFFFFFE,   32'd2,          1'b0, 32'd0},
    '{32'hFFFFFFFF,     32'hFFFFFFFE,   32'hFFFFFFFF,   1'b0, 32'd0},
    '{32'hFFFFFFFF,     32'd2,          32'd31,         1'b1, 32'h80000000},
    '{32'hFFFFFFFF,     32'd2,          32'd32,         1'b0, 32'd0}
  };

  modular_exponentiation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  // clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one reduction step; a zero modulus keeps the low 32 bits
  function automatic logic [63:0] reduce_mod(logic [63:0] x, logic [31:0] m);
    if (m == 32'd0) return x & 64'h0000_0000_FFFF_FFFF;
    return x % {32'd0, m};
  endfunction

  // right-to-left square and multiply with the block's special cases
  function automatic logic [31:0] power_residue_of(logic [31:0] b_in, logic [31:0] e_in,
                                                   logic [31:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [31:0] e;
    acc = 64'd1;
    sq  = {32'd0, b_in};
    e   = e_in;
    if (b_in == 32'd0) return 32'd0;
    if (e == 32'd0) return 32'd1;
    if (sq > {32'd0, m}) sq = reduce_mod(sq, m);
    if (e == 32'd1) return sq[31:0];
    while (e != 32'd0) begin
      if (e[0]) acc = reduce_mod(acc * sq, m);
      sq = reduce_mod(sq * sq, m);
      e  = e >> 1;
    end
    return acc[31:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %08h want %08h", $realtime, what, got, want);
    mismatches++;
  endtask

  // result check, request prediction and watchdog
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (residue_q.size() == 0) begin
          report_mismatch("result with no request pending", out_tdata, 32'd0);
        end else begin
          want = residue_q.pop_front();
          if (out_tdata !== want) report_mismatch("power_residue", out_tdata, want);
        end
      end
      if (in_tvalid && in_tready) begin
        residue_q.push_back(offer_known ? offer_residue :
                            power_residue_of(in_tdata[31:0], in_tdata[63:32], modulus_now));
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
      end
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result side: random idling, bursts, and one long hold-off
  initial begin : sink
    int  gap;
    bit  held;
    held = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = recv_burst ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // offer one request, called at a falling edge, returns at a falling edge
  task automatic send_request(logic [31:0] base_value, logic [31:0] exponent,
                              logic known, logic [31:0] residue);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata      = {exponent, base_value};
    offer_known   = known;
    offer_residue = residue;
    in_tvalid     = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // wait until every result is back, then let the block settle
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (residue_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // modulus write while idle
  task automatic write_modulus(logic [31:0] value);
    drain_results();
    cfg_wen   = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wen     = 1'b0;
    modulus_now = value;
    @(negedge clk);
  endtask

  // stimulus
  initial begin : stimulus
    logic [31:0] next_mod;
    logic [31:0] b;
    logic [31:0] e;
    int          pick;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed rows
    foreach (directed_rows[i]) begin
      if (directed_rows[i].modulus != modulus_now) write_modulus(directed_rows[i].modulus);
      send_request(directed_rows[i].base_value, directed_rows[i].exponent,
                   directed_rows[i].known, directed_rows[i].residue);
    end

    // random phases, one modulus setting each
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       next_mod = $urandom | 32'h80000000;
        1:       next_mod = $urandom_range(2, 255);
        2:       next_mod = 32'd1;
        3:       next_mod = 32'hFFFFFFFF;
        4:       next_mod = $urandom_range(2, 65535);
        5:       next_mod = 32'h80000000;
        default: next_mod = $urandom;
      endcase
      if (next_mod == 32'd0) next_mod = 32'd1;
      write_modulus(next_mod);
      for (int k = 0; k < PER_PHASE; k++) begin
        // base: zero, around the modulus, small, or anything
        pick = $urandom_range(0, 15);
        case (pick)
          0:       b = 32'd0;
          1:       b = modulus_now;
          2:       b = modulus_now + 32'd1;
          3:       b = modulus_now - 32'd1;
          4, 5, 6: b = $urandom_range(0, 15);
          default: b = $urandom;
        endcase
        // exponent: mostly short, a few full width to keep run time sane
        pick = $urandom_range(0, 15);
        case (pick)
          0:       e = 32'd0;
          1:       e = 32'd1;
          2, 3:    e = $urandom;
          default: e = $urandom_range(2, 1023);
        endcase
        send_request(b, e, 1'b0, 32'd0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_mulmod.sv
hw/rtl/mexp_useq.sv
hw/rtl/modular_exponentiation.sv
hw/rtl/mexp_checker.sv
test/tb_modular_exponentiation.sv
